### sv/cta_pkg.sv
package cta_pkg;

	// field widths
	localparam int YEAR_W = 14;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;
	localparam int MS_W   = 10;
	localparam int WDAY_W = 3;

	// field limits
	localparam int YEAR_MAX = 9999;
	localparam int YEAR_MOD = 10000;
	localparam int MON_MAX  = 12;
	localparam int HOUR_MAX = 23;
	localparam int MIN_MAX  = 59;
	localparam int SEC_MAX  = 59;
	localparam int MS_MAX   = 999;
	localparam int WDAY_MAX = 6;
	localparam int WDAY_MOD = 7;

	// month walk limit in each direction
	localparam int WALK_MAX = 4;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_SUB  = 2'd2,
		CMD_CMP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_LEAP,
		ST_SETTLE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic calc;
		logic step;
		logic commit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic step_need;
		logic out_free;
	} sts_t;

endpackage

### sv/calendar_time_add_subtract_unit.sv
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+-------------------------------------------
// input     | in  | in_valid / in_ready  | command, in_year .. in_week_day
// result    | out | out_valid / out_ready| out_year .. out_week_day, is_earlier, is_later
//
// an item goes through take, carry chain, year / 100 update and commit, with one
// month of the day walk per step before the commit; the month walk loop sets the range
// reset clears the stored value to year 0, January 1, 00:00:00.000, week day 0
// the result sits in an output register; the next item is taken and worked on
// while it waits, and only its commit waits for the output register to free
module calendar_time_add_subtract_unit
	import cta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [YEAR_W-1:0]   in_year,
	input  logic [MON_W-1:0]    in_month,
	input  logic [DAY_W-1:0]    in_day,
	input  logic [HOUR_W-1:0]   in_hour,
	input  logic [MIN_W-1:0]    in_minute,
	input  logic [SEC_W-1:0]    in_second,
	input  logic [MS_W-1:0]     in_millis,
	input  logic [WDAY_W-1:0]   in_week_day,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [YEAR_W-1:0]   out_year,
	output logic [MON_W-1:0]    out_month,
	output logic [DAY_W-1:0]    out_day,
	output logic [HOUR_W-1:0]   out_hour,
	output logic [MIN_W-1:0]    out_minute,
	output logic [SEC_W-1:0]    out_second,
	output logic [MS_W-1:0]     out_millis,
	output logic [WDAY_W-1:0]   out_week_day,
	output logic                is_earlier,
	output logic                is_later
);

	ctl_t ctl;
	sts_t sts;

	// sequencer
	cta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// date-time registers and arithmetic
	cta_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.in_year      (in_year),
		.in_month     (in_month),
		.in_day       (in_day),
		.in_hour      (in_hour),
		.in_minute    (in_minute),
		.in_second    (in_second),
		.in_millis    (in_millis),
		.in_week_day  (in_week_day),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_year     (out_year),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_hour     (out_hour),
		.out_minute   (out_minute),
		.out_second   (out_second),
		.out_millis   (out_millis),
		.out_week_day (out_week_day),
		.is_earlier   (is_earlier),
		.is_later     (is_later)
	);

endmodule

### sv/cta_ctrl.sv
module cta_ctrl
	import cta_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output ctl_t   ctl
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				state_nxt = ST_LEAP;
			end
			ST_LEAP: begin
				state_nxt = ST_SETTLE;
			end
			ST_SETTLE: begin
				if (!sts.step_need && sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		in_ready   = 1'b0;
		ctl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.take = in_valid;
			end
			ST_CALC: begin
				ctl.calc = 1'b1;
			end
			ST_LEAP: begin
			end
			ST_SETTLE: begin
				ctl.step   = sts.step_need;
				ctl.commit = !sts.step_need && sts.out_free;
			end
			default: begin
			end
		endcase
	end

	// controller checks
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> state_q == ST_CALC)
		else $error("transfer taken but no compute cycle followed");

	a_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.commit && ctl.step))
		else $error("commit and month step in the same cycle");

endmodule

### sv/cta_datapath.sv
module cta_datapath
	import cta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  logic [1:0]          command,
	input  logic [YEAR_W-1:0]   in_year,
	input  logic [MON_W-1:0]    in_month,
	input  logic [DAY_W-1:0]    in_day,
	input  logic [HOUR_W-1:0]   in_hour,
	input  logic [MIN_W-1:0]    in_minute,
	input  logic [SEC_W-1:0]    in_second,
	input  logic [MS_W-1:0]     in_millis,
	input  logic [WDAY_W-1:0]   in_week_day,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [YEAR_W-1:0]   out_year,
	output logic [MON_W-1:0]    out_month,
	output logic [DAY_W-1:0]    out_day,
	output logic [HOUR_W-1:0]   out_hour,
	output logic [MIN_W-1:0]    out_minute,
	output logic [SEC_W-1:0]    out_second,
	output logic [MS_W-1:0]     out_millis,
	output logic [WDAY_W-1:0]   out_week_day,
	output logic                is_earlier,
	output logic                is_later
);

	localparam int PACK_W = YEAR_W + MON_W + DAY_W + HOUR_W + MIN_W + SEC_W + MS_W;

	function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mo,
		input logic lp);
		logic [DAY_W-1:0] n;
		begin
			case (mo)
				4'd2:    n = lp ? 5'd29 : 5'd28;
				4'd4,
				4'd6,
				4'd9,
				4'd11:   n = 5'd30;
				default: n = 5'd31;
			endcase
			return n;
		end
	endfunction

	// stored date-time, also the working registers during an item
	logic [YEAR_W-1:0]  yr_q;
	logic [MON_W-1:0]   mo_q;
	logic signed [7:0]  day_q;
	logic [HOUR_W-1:0]  hr_q;
	logic [MIN_W-1:0]   mi_q;
	logic [SEC_W-1:0]   se_q;
	logic [MS_W-1:0]    ms_q;
	logic [WDAY_W-1:0]  wk_q;

	// latched command and input fields, all but the day saturated
	cmd_t               op_q;
	logic [YEAR_W-1:0]  dyr_q;
	logic [MON_W-1:0]   dmo_q;
	logic [DAY_W-1:0]   dd_q;
	logic [HOUR_W-1:0]  dhr_q;
	logic [MIN_W-1:0]   dmi_q;
	logic [SEC_W-1:0]   dse_q;
	logic [MS_W-1:0]    dms_q;
	logic [WDAY_W-1:0]  dwk_q;
	logic               earlier_q;
	logic               later_q;

	// month walk counters and year / 100
	logic [2:0]         bcnt_q;
	logic [2:0]         fcnt_q;
	logic [6:0]         q100_q;

	// result register
	logic               out_valid_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic [MON_W-1:0]   out_month_q;
	logic [DAY_W-1:0]   out_day_q;
	logic [HOUR_W-1:0]  out_hour_q;
	logic [MIN_W-1:0]   out_minute_q;
	logic [SEC_W-1:0]   out_second_q;
	logic [MS_W-1:0]    out_millis_q;
	logic [WDAY_W-1:0]  out_week_day_q;
	logic               is_earlier_q;
	logic               is_later_q;

	// input side: saturation and compare
	logic [PACK_W-1:0]  cur_pack;
	logic [PACK_W-1:0]  given;
	cmd_t               cmd_in;
	logic [WDAY_W-1:0]  wk_sat;

	assign cur_pack = {yr_q, mo_q, day_q[DAY_W-1:0], hr_q, mi_q, se_q, ms_q};
	assign given  = {in_year, in_month, in_day, in_hour, in_minute, in_second, in_millis};
	assign cmd_in = cmd_t'(command);

	// week day: load takes it modulo 7, a duration saturates at 6
	always_comb begin
		if (in_week_day == WDAY_W'(WDAY_MOD)) begin
			wk_sat = (cmd_in == CMD_LOAD) ? '0 : WDAY_W'(WDAY_MAX);
		end else begin
			wk_sat = in_week_day;
		end
	end

	// leap year from year and registered year / 100
	logic [25:0]        q100_prod;
	logic               rem_zero;
	logic               leap;

	assign q100_prod = 26'(yr_q) * 26'd5243;
	assign rem_zero  = yr_q == (YEAR_W'(q100_q) * YEAR_W'(100));
	assign leap      = (yr_q[1:0] == 2'b00) && (!rem_zero || (q100_q[1:0] == 2'b00));

	// carry chain for add and subtract
	logic               is_sub;
	logic               arith;
	logic signed [11:0] v_ms;
	logic signed [7:0]  v_se;
	logic signed [7:0]  v_mi;
	logic signed [6:0]  v_hr;
	logic signed [7:0]  v_day;
	logic signed [4:0]  v_wk;
	logic signed [5:0]  v_mo;
	logic signed [15:0] v_yr;
	logic signed [1:0]  c_ms;
	logic signed [1:0]  c_se;
	logic signed [1:0]  c_mi;
	logic signed [1:0]  c_hr;
	logic signed [1:0]  c_mo;
	logic signed [11:0] x_ms;
	logic signed [7:0]  x_se;
	logic signed [7:0]  x_mi;
	logic signed [6:0]  x_hr;
	logic signed [7:0]  x_day;
	logic signed [4:0]  x_wk;
	logic signed [5:0]  x_mo;
	logic signed [15:0] x_yr;
	logic [MS_W-1:0]    n_ms;
	logic [SEC_W-1:0]   n_se;
	logic [MIN_W-1:0]   n_mi;
	logic [HOUR_W-1:0]  n_hr;
	logic [WDAY_W-1:0]  n_wk;
	logic [MON_W-1:0]   n_mo;
	logic [YEAR_W-1:0]  n_yr;

	assign is_sub = op_q == CMD_SUB;
	assign arith  = (op_q == CMD_ADD) || (op_q == CMD_SUB);

	always_comb begin
		x_ms  = $signed({2'b00, dms_q});
		x_se  = $signed({2'b00, dse_q});
		x_mi  = $signed({2'b00, dmi_q});
		x_hr  = $signed({2'b00, dhr_q});
		x_day = $signed({3'b000, dd_q});
		x_wk  = $signed({2'b00, dwk_q});
		x_mo  = $signed({2'b00, dmo_q});
		x_yr  = $signed({2'b00, dyr_q});

		// milliseconds
		v_ms = $signed({2'b00, ms_q}) + (is_sub ? -x_ms : x_ms);
		if (v_ms >= 12'sd1000) begin
			n_ms = MS_W'(v_ms - 12'sd1000);
			c_ms = 2'sd1;
		end else if (v_ms < 12'sd0) begin
			n_ms = MS_W'(v_ms + 12'sd1000);
			c_ms = -2'sd1;
		end else begin
			n_ms = v_ms[MS_W-1:0];
			c_ms = 2'sd0;
		end

		// seconds
		v_se = $signed({2'b00, se_q}) + (is_sub ? -x_se : x_se) + c_ms;
		if (v_se >= 8'sd60) begin
			n_se = SEC_W'(v_se - 8'sd60);
			c_se = 2'sd1;
		end else if (v_se < 8'sd0) begin
			n_se = SEC_W'(v_se + 8'sd60);
			c_se = -2'sd1;
		end else begin
			n_se = v_se[SEC_W-1:0];
			c_se = 2'sd0;
		end

		// minutes
		v_mi = $signed({2'b00, mi_q}) + (is_sub ? -x_mi : x_mi) + c_se;
		if (v_mi >= 8'sd60) begin
			n_mi = MIN_W'(v_mi - 8'sd60);
			c_mi = 2'sd1;
		end else if (v_mi < 8'sd0) begin
			n_mi = MIN_W'(v_mi + 8'sd60);
			c_mi = -2'sd1;
		end else begin
			n_mi = v_mi[MIN_W-1:0];
			c_mi = 2'sd0;
		end

		// hours
		v_hr = $signed({2'b00, hr_q}) + (is_sub ? -x_hr : x_hr) + c_mi;
		if (v_hr >= 7'sd24) begin
			n_hr = HOUR_W'(v_hr - 7'sd24);
			c_hr = 2'sd1;
		end else if (v_hr < 7'sd0) begin
			n_hr = HOUR_W'(v_hr + 7'sd24);
			c_hr = -2'sd1;
		end else begin
			n_hr = v_hr[HOUR_W-1:0];
			c_hr = 2'sd0;
		end

		// raw day and week day
		v_day = day_q + (is_sub ? -x_day : x_day) + c_hr;
		v_wk  = $signed({2'b00, wk_q}) + (is_sub ? -x_wk : x_wk) + c_hr;
		if (v_wk >= 5'sd7) begin
			n_wk = WDAY_W'(v_wk - 5'sd7);
		end else if (v_wk < 5'sd0) begin
			n_wk = WDAY_W'(v_wk + 5'sd7);
		end else begin
			n_wk = v_wk[WDAY_W-1:0];
		end

		// month moves by twelve
		v_mo = $signed({2'b00, mo_q}) + (is_sub ? -x_mo : x_mo);
		if (v_mo > 6'sd12) begin
			n_mo = MON_W'(v_mo - 6'sd12);
			c_mo = 2'sd1;
		end else if (v_mo <= 6'sd0) begin
			n_mo = MON_W'(v_mo + 6'sd12);
			c_mo = -2'sd1;
		end else begin
			n_mo = v_mo[MON_W-1:0];
			c_mo = 2'sd0;
		end

		// year modulo 10000
		v_yr = $signed({2'b00, yr_q}) + (is_sub ? -x_yr : x_yr) + c_mo;
		if (v_yr >= 16'sd10000) begin
			n_yr = YEAR_W'(v_yr - 16'sd10000);
		end else if (v_yr < 16'sd0) begin
			n_yr = YEAR_W'(v_yr + 16'sd10000);
		end else begin
			n_yr = v_yr[YEAR_W-1:0];
		end
	end

	// month walk for the day
	logic [MON_W-1:0]   prev_mo;
	logic [YEAR_W-1:0]  prev_yr;
	logic [MON_W-1:0]   next_mo;
	logic [YEAR_W-1:0]  next_yr;
	logic [DAY_W-1:0]   len_cur;
	logic [DAY_W-1:0]   len_prev;
	logic               back_need;
	logic               fwd_need;
	logic [DAY_W-1:0]   fin_day;

	always_comb begin
		if (mo_q <= MON_W'(1)) begin
			prev_mo = MON_W'(MON_MAX);
			prev_yr = (yr_q == '0) ? YEAR_W'(YEAR_MAX) : yr_q - YEAR_W'(1);
		end else begin
			prev_mo = mo_q - MON_W'(1);
			prev_yr = yr_q;
		end
		if (mo_q >= MON_W'(MON_MAX)) begin
			next_mo = MON_W'(1);
			next_yr = (yr_q == YEAR_W'(YEAR_MAX)) ? '0 : yr_q + YEAR_W'(1);
		end else begin
			next_mo = mo_q + MON_W'(1);
			next_yr = yr_q;
		end
		// only March looks back into February, which is in the same year
		len_cur  = month_days(mo_q, leap);
		len_prev = month_days(prev_mo, leap);

		back_need = arith && (day_q <= 8'sd0) && (bcnt_q < 3'(WALK_MAX));
		fwd_need  = arith && !back_need && (day_q > $signed({3'b000, len_cur}))
			&& (fcnt_q < 3'(WALK_MAX));

		if (op_q == CMD_LOAD) begin
			fin_day = (day_q > $signed({3'b000, len_cur})) ? len_cur : day_q[DAY_W-1:0];
		end else if (arith && (day_q < 8'sd1)) begin
			fin_day = DAY_W'(1);
		end else begin
			fin_day = day_q[DAY_W-1:0];
		end
	end

	assign sts.step_need = back_need || fwd_need;
	assign sts.out_free  = !out_valid_q || out_ready;

	// stored value, walk counters and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yr_q        <= '0;
			mo_q        <= MON_W'(1);
			day_q       <= 8'sd1;
			hr_q        <= '0;
			mi_q        <= '0;
			se_q        <= '0;
			ms_q        <= '0;
			wk_q        <= '0;
			bcnt_q      <= '0;
			fcnt_q      <= '0;
			q100_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			q100_q <= q100_prod[25:19];
			if (ctl.calc) begin
				bcnt_q <= '0;
				fcnt_q <= '0;
				if (op_q == CMD_LOAD) begin
					yr_q  <= dyr_q;
					mo_q  <= (dmo_q == '0) ? MON_W'(1) : dmo_q;
					day_q <= (dd_q == '0) ? 8'sd1 : $signed({3'b000, dd_q});
					hr_q  <= dhr_q;
					mi_q  <= dmi_q;
					se_q  <= dse_q;
					ms_q  <= dms_q;
					wk_q  <= dwk_q;
				end else if (arith) begin
					yr_q  <= n_yr;
					mo_q  <= n_mo;
					day_q <= v_day;
					hr_q  <= n_hr;
					mi_q  <= n_mi;
					se_q  <= n_se;
					ms_q  <= n_ms;
					wk_q  <= n_wk;
				end
			end
			if (ctl.step) begin
				if (back_need) begin
					mo_q   <= prev_mo;
					yr_q   <= prev_yr;
					day_q  <= day_q + $signed({3'b000, len_prev});
					bcnt_q <= bcnt_q + 3'd1;
				end else begin
					mo_q   <= next_mo;
					yr_q   <= next_yr;
					day_q  <= day_q - $signed({3'b000, len_cur});
					fcnt_q <= fcnt_q + 3'd1;
				end
			end
			if (ctl.commit) begin
				day_q       <= $signed({3'b000, fin_day});
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input latch and result payload
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q      <= cmd_in;
			dyr_q     <= (in_year > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : in_year;
			dmo_q     <= (in_month > MON_W'(MON_MAX)) ? MON_W'(MON_MAX) : in_month;
			dd_q      <= in_day;
			dhr_q     <= (in_hour > HOUR_W'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : in_hour;
			dmi_q     <= (in_minute > MIN_W'(MIN_MAX)) ? MIN_W'(MIN_MAX) : in_minute;
			dse_q     <= (in_second > SEC_W'(SEC_MAX)) ? SEC_W'(SEC_MAX) : in_second;
			dms_q     <= (in_millis > MS_W'(MS_MAX)) ? MS_W'(MS_MAX) : in_millis;
			dwk_q     <= wk_sat;
			earlier_q <= cur_pack < given;
			later_q   <= cur_pack > given;
		end
		if (ctl.commit) begin
			out_year_q     <= yr_q;
			out_month_q    <= mo_q;
			out_day_q      <= fin_day;
			out_hour_q     <= hr_q;
			out_minute_q   <= mi_q;
			out_second_q   <= se_q;
			out_millis_q   <= ms_q;
			out_week_day_q <= wk_q;
			is_earlier_q   <= earlier_q;
			is_later_q     <= later_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_year     = out_year_q;
	assign out_month    = out_month_q;
	assign out_day      = out_day_q;
	assign out_hour     = out_hour_q;
	assign out_minute   = out_minute_q;
	assign out_second   = out_second_q;
	assign out_millis   = out_millis_q;
	assign out_week_day = out_week_day_q;
	assign is_earlier   = is_earlier_q;
	assign is_later     = is_later_q;

	// datapath checks
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> out_valid_q)
		else $error("result not presented after commit");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (day_q >= 8'sd1) && (day_q <= $signed({3'b000, len_cur})))
		else $error("stored day outside its month after commit");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (mo_q >= MON_W'(1)) && (mo_q <= MON_W'(MON_MAX)))
		else $error("stored month out of range after commit");

	a_order_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(is_earlier_q && is_later_q))
		else $error("result flagged both earlier and later");

endmodule
